/* sv/tbd_pkg.sv */
package tbd_pkg;

   localparam int MAX_WORKERS = 16;
   localparam int STACK_DEPTH = 64;

   localparam int WID_W  = 5;                      // worker id field, 0..MAX_WORKERS
   localparam int WIDX_W = $clog2(MAX_WORKERS);    // index into the busy flags
   localparam int SP_W   = $clog2(STACK_DEPTH);    // stack address
   localparam int CNT_W  = $clog2(STACK_DEPTH) + 1; // stack fill, 0..STACK_DEPTH
   localparam int CSR_IDX_W = 2;

   localparam logic [1:0] CMD_START  = 2'd0;
   localparam logic [1:0] CMD_SPLIT  = 2'd1;
   localparam logic [1:0] CMD_AREA   = 2'd2;
   localparam logic [1:0] CMD_UNUSED = 2'd3;     // no meaning, dropped without a result

   localparam logic [1:0] KIND_TASK  = 2'd0;
   localparam logic [1:0] KIND_QUIT  = 2'd1;
   localparam logic [1:0] KIND_TOTAL = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_WORKER_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_RANGE_LOW    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_RANGE_HIGH   = 2'd2;

   localparam logic [WID_W-1:0]  RST_WORKER_COUNT = 5'd4;
   localparam logic [31:0]       RST_RANGE_LOW    = 32'd0;
   localparam logic [31:0]       RST_RANGE_HIGH   = 32'd83886080; // 5.0 in Q8.24

   typedef struct packed {
      logic            we;
      logic [SP_W-1:0] addr;
      logic [63:0]     data;
   } tbd_ram_wr_type;

   typedef struct packed {
      logic              start;
      logic signed [32:0] dividend;
      logic [WID_W-1:0]  divisor;
   } tbd_div_req_type;

   typedef struct packed {
      logic              done;
      logic signed [32:0] quotient;
   } tbd_div_rsp_type;

endpackage

/* sv/tbd_req_if.sv */
interface tbd_req_if;
   import tbd_pkg::*;
   logic              valid;
   logic              ready;
   logic [1:0]        cmd;
   logic [WID_W-1:0]  worker_id;
   logic signed [31:0] split_left;
   logic signed [31:0] split_mid;
   logic signed [31:0] split_right;
   logic signed [63:0] piece_area;
   modport source (output valid, cmd, worker_id, split_left, split_mid, split_right,
                   piece_area, input ready);
   modport sink   (input valid, cmd, worker_id, split_left, split_mid, split_right,
                   piece_area, output ready);
endinterface

/* sv/tbd_rsp_if.sv */
interface tbd_rsp_if;
   import tbd_pkg::*;
   logic              valid;
   logic              ready;
   logic [1:0]        kind;
   logic [WID_W-1:0]  dest_worker;
   logic signed [31:0] task_left;
   logic signed [31:0] task_right;
   logic signed [63:0] total_area;
   logic              overflow;
   logic              last;
   modport source (output valid, kind, dest_worker, task_left, task_right, total_area,
                   overflow, last, input ready);
   modport sink   (input valid, kind, dest_worker, task_left, task_right, total_area,
                   overflow, last, output ready);
endinterface

/* sv/tbd_csr_if.sv */
interface tbd_csr_if;
   import tbd_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [31:0]          data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

/* sv/tbd_stack_ram.sv */
module tbd_stack_ram (
   input  logic                    clock,
   input  tbd_pkg::tbd_ram_wr_type wr,
   input  logic                    rd_en,
   input  logic [tbd_pkg::SP_W-1:0] rd_addr,
   output logic [63:0]             rd_data_ff
);
   import tbd_pkg::*;

   logic [63:0] mem [STACK_DEPTH];

   always_ff @(posedge clock) begin
      if (wr.we) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

/* sv/tbd_div.sv */
// Restoring divide of a signed 33-bit value by a small unsigned count, one bit a cycle.
module tbd_div (
   input  logic                     clock,
   input  logic                     reset,
   input  tbd_pkg::tbd_div_req_type req,
   output tbd_pkg::tbd_div_rsp_type rsp
);
   import tbd_pkg::*;

   logic [32:0]       mag_ff, mag_in;
   logic [WID_W:0]    rem_ff, rem_in;
   logic [5:0]        cnt_ff, cnt_in;
   logic              neg_ff, neg_in;
   logic              act_ff, act_in;
   logic [WID_W-1:0]  dvs_ff, dvs_in;
   logic              done_ff, done_in;
   logic [WID_W:0]    trial;

   always_comb begin
      mag_in  = mag_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      act_in  = act_ff;
      dvs_in  = dvs_ff;
      done_in = 1'b0;
      trial   = {rem_ff[WID_W-1:0], mag_ff[32]};
      if (req.start) begin
         neg_in = req.dividend[32];
         mag_in = req.dividend[32] ? 33'(-req.dividend) : req.dividend;
         rem_in = '0;
         cnt_in = 6'd33;
         dvs_in = req.divisor;
         act_in = 1'b1;
      end else if (act_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = trial - {1'b0, dvs_ff};
            mag_in = {mag_ff[31:0], 1'b1};
         end else begin
            rem_in = trial;
            mag_in = {mag_ff[31:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            act_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         act_ff  <= act_in;
         done_ff <= done_in;
      end
      mag_ff <= mag_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      neg_ff <= neg_in;
      dvs_ff <= dvs_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = neg_ff ? 33'(-mag_ff) : mag_ff;

endmodule

/* sv/task_bag_dispatcher_top.sv */
// Channel  | Dir | Carries
// ---------+-----+---------------------------------------------------------------
// req_ch   | in  | start / split / area message: cmd, worker_id, bounds, area
// rsp_ch   | out | task dispatch, quit, final total; overflow and last flags
// csr_ch   | in  | register write: index 0 worker_count, 1 range_low, 2 range_high
//
// Flow: a start runs the serial divide, then dispatches one segment per worker.
// A split pushes both halves, searches circularly for an idle worker, and pops
// tasks to it and to the sender; an area adds to the total and pops a task, or
// at job end sends quits and the total; others are ignored. Reset is synchronous,
// active high, and clears all control state; the stack needs no clearing. A
// stalled rsp_ch holds the engine in its emit state; req_ch is taken only in idle.
module task_bag_dispatcher_top (
   input logic      clock,
   input logic      reset,
   tbd_req_if.sink  req_ch,
   tbd_rsp_if.source rsp_ch,
   tbd_csr_if.sink  csr_ch
);
   import tbd_pkg::*;

   localparam logic [3:0] ST_IDLE    = 4'd0;
   localparam logic [3:0] ST_DIV     = 4'd1;
   localparam logic [3:0] ST_SEG     = 4'd2;
   localparam logic [3:0] ST_PUSH1   = 4'd3;
   localparam logic [3:0] ST_PUSH2   = 4'd4;
   localparam logic [3:0] ST_SEARCH  = 4'd5;
   localparam logic [3:0] ST_POPF_RD = 4'd6;
   localparam logic [3:0] ST_POPF_EM = 4'd7;
   localparam logic [3:0] ST_POPW_CK = 4'd8;
   localparam logic [3:0] ST_POPW_RD = 4'd9;
   localparam logic [3:0] ST_POPW_EM = 4'd10;
   localparam logic [3:0] ST_DONE_CK = 4'd11;
   localparam logic [3:0] ST_QUIT    = 4'd12;
   localparam logic [3:0] ST_TOTAL   = 4'd13;

   // configuration
   logic [WID_W-1:0] wc_ff, wc_in;
   logic [31:0]      rlo_ff, rlo_in, rhi_ff, rhi_in;

   // job state
   logic [3:0]            state_ff, state_in;
   logic [WID_W-1:0]      n_ff, n_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [MAX_WORKERS-1:0] busy_ff, busy_in;
   logic [63:0]           total_ff, total_in;
   logic                  run_ff, run_in;
   logic                  drop_ff, drop_in;
   logic [WID_W-1:0]      who_ff, who_in, found_ff, found_in;
   logic [WID_W-1:0]      idx_ff, idx_in, jcnt_ff, jcnt_in;
   logic [31:0]           p_ff, p_in, step_ff, step_in;
   logic [31:0]           left_ff, left_in, mid_ff, mid_in, right_ff, right_in;

   // result register
   logic                  ov_ff, ov_in;
   logic [1:0]            kind_ff, kind_in;
   logic [WID_W-1:0]      dest_ff, dest_in;
   logic [31:0]           tl_ff, tl_in, tr_ff, tr_in;
   logic [63:0]           ta_ff, ta_in;
   logic                  ovf_ff, ovf_in, last_ff, last_in;

   logic                  slot_free, emit;
   logic [1:0]            e_kind;
   logic [WID_W-1:0]      e_dest;
   logic [31:0]           e_left, e_right;
   logic [63:0]           e_total;
   logic                  e_last;

   tbd_ram_wr_type        ram_wr;
   logic                  ram_re;
   logic [SP_W-1:0]       ram_raddr;
   logic [63:0]           ram_rdata;
   tbd_div_req_type       div_req;
   tbd_div_rsp_type       div_rsp;

   logic [WID_W-1:0]      n_start;
   logic                  msg_ok, all_idle;
   logic [63:0]           sum;
   logic [WIDX_W-1:0]     who_idx, found_idx, idx_w;
   logic [WID_W-1:0]      idx_next;

   tbd_stack_ram u_stack (
      .clock     (clock),
      .wr        (ram_wr),
      .rd_en     (ram_re),
      .rd_addr   (ram_raddr),
      .rd_data_ff(ram_rdata)
   );

   tbd_div u_div (
      .clock(clock),
      .reset(reset),
      .req  (div_req),
      .rsp  (div_rsp)
   );

   assign slot_free   = !ov_ff || rsp_ch.ready;
   assign req_ch.ready = (state_ff == ST_IDLE);
   assign csr_ch.ready = 1'b1;

   assign who_idx   = WIDX_W'(who_ff - WID_W'(1));
   assign found_idx = WIDX_W'(found_ff - WID_W'(1));
   assign idx_w     = idx_ff[WIDX_W-1:0];
   assign idx_next  = (idx_ff + WID_W'(1) == n_ff) ? '0 : idx_ff + WID_W'(1);

   // saturate worker count to 1..MAX_WORKERS
   always_comb begin
      if (wc_ff == '0) begin
         n_start = WID_W'(1);
      end else if (wc_ff > WID_W'(MAX_WORKERS)) begin
         n_start = WID_W'(MAX_WORKERS);
      end else begin
         n_start = wc_ff;
      end
   end

   assign msg_ok = run_ff && (req_ch.cmd != CMD_UNUSED) && (req_ch.worker_id != '0)
                   && (req_ch.worker_id <= n_ff);

   always_comb begin
      all_idle = 1'b1;
      for (int i = 0; i < MAX_WORKERS; i++) begin
         if ((WID_W'(i) < n_ff) && busy_ff[i]) begin
            all_idle = 1'b0;
         end
      end
   end

   // saturating Q32.32 accumulate
   always_comb begin
      sum = total_ff + req_ch.piece_area;
      if ((total_ff[63] == req_ch.piece_area[63]) && (sum[63] != total_ff[63])) begin
         sum = total_ff[63] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
      end
   end

   always_comb begin
      wc_in    = wc_ff;
      rlo_in   = rlo_ff;
      rhi_in   = rhi_ff;
      state_in = state_ff;
      n_in     = n_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      total_in = total_ff;
      run_in   = run_ff;
      drop_in  = drop_ff;
      who_in   = who_ff;
      found_in = found_ff;
      idx_in   = idx_ff;
      jcnt_in  = jcnt_ff;
      p_in     = p_ff;
      step_in  = step_ff;
      left_in  = left_ff;
      mid_in   = mid_ff;
      right_in = right_ff;
      emit     = 1'b0;
      e_kind   = KIND_TASK;
      e_dest   = '0;
      e_left   = '0;
      e_right  = '0;
      e_total  = '0;
      e_last   = 1'b0;
      ram_wr   = '0;
      ram_re   = 1'b0;
      ram_raddr = SP_W'(cnt_ff - CNT_W'(1));
      div_req.start    = 1'b0;
      div_req.dividend = {rhi_ff[31], rhi_ff} - {rlo_ff[31], rlo_ff};
      div_req.divisor  = n_start;

      if (csr_ch.valid) begin
         case (csr_ch.index)
            REG_WORKER_COUNT: wc_in  = csr_ch.data[WID_W-1:0];
            REG_RANGE_LOW:    rlo_in = csr_ch.data;
            REG_RANGE_HIGH:   rhi_in = csr_ch.data;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               who_in   = req_ch.worker_id;
               left_in  = req_ch.split_left;
               mid_in   = req_ch.split_mid;
               right_in = req_ch.split_right;
               drop_in  = 1'b0;
               if (req_ch.cmd == CMD_START) begin
                  // restart: clear the job and launch the segment divide
                  n_in          = n_start;
                  cnt_in        = '0;
                  total_in      = '0;
                  busy_in       = '0;
                  run_in        = 1'b1;
                  p_in          = rlo_ff;
                  idx_in        = '0;
                  div_req.start = 1'b1;
                  state_in      = ST_DIV;
               end else if (msg_ok && req_ch.cmd == CMD_SPLIT) begin
                  state_in = ST_PUSH1;
               end else if (msg_ok && req_ch.cmd == CMD_AREA) begin
                  total_in = sum;
                  busy_in[WIDX_W'(req_ch.worker_id - WID_W'(1))] = 1'b0;
                  state_in = ST_POPW_CK;
               end
            end
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               step_in  = div_rsp.quotient[31:0];
               state_in = ST_SEG;
            end
         end
         ST_SEG: begin
            if (slot_free) begin
               emit    = 1'b1;
               e_dest  = idx_ff + WID_W'(1);
               e_left  = p_ff;
               e_right = p_ff + step_ff;
               e_last  = (idx_ff + WID_W'(1) == n_ff);
               busy_in[idx_w] = 1'b1;
               p_in    = p_ff + step_ff;
               idx_in  = idx_ff + WID_W'(1);
               if (e_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_PUSH1, ST_PUSH2: begin
            if (cnt_ff < CNT_W'(STACK_DEPTH)) begin
               ram_wr.we   = 1'b1;
               ram_wr.addr = cnt_ff[SP_W-1:0];
               ram_wr.data = (state_ff == ST_PUSH1) ? {left_ff, mid_ff} : {mid_ff, right_ff};
               cnt_in      = cnt_ff + CNT_W'(1);
            end else begin
               drop_in = 1'b1;
            end
            if (state_ff == ST_PUSH2) begin
               idx_in   = who_ff - WID_W'(1);
               jcnt_in  = '0;
               state_in = ST_SEARCH;
            end else begin
               state_in = ST_PUSH2;
            end
         end
         ST_SEARCH: begin
            // one worker a cycle, circularly from the sender
            if (!busy_ff[idx_w] || jcnt_ff + WID_W'(1) == n_ff) begin
               found_in = busy_ff[idx_w] ? who_ff : idx_ff + WID_W'(1);
               busy_in[who_idx] = 1'b1;
               if (found_in != who_ff && cnt_ff != '0) begin
                  state_in = ST_POPF_RD;
               end else begin
                  state_in = ST_POPW_CK;
               end
            end else begin
               idx_in  = idx_next;
               jcnt_in = jcnt_ff + WID_W'(1);
            end
         end
         ST_POPF_RD, ST_POPW_RD: begin
            ram_re   = 1'b1;
            cnt_in   = cnt_ff - CNT_W'(1);
            state_in = (state_ff == ST_POPF_RD) ? ST_POPF_EM : ST_POPW_EM;
         end
         ST_POPF_EM: begin
            if (slot_free) begin
               emit    = 1'b1;
               e_dest  = found_ff;
               e_left  = ram_rdata[63:32];
               e_right = ram_rdata[31:0];
               e_last  = (cnt_ff == '0);
               busy_in[found_idx] = 1'b1;
               state_in = ST_POPW_CK;
            end
         end
         ST_POPW_CK: begin
            state_in = (cnt_ff != '0) ? ST_POPW_RD : ST_DONE_CK;
         end
         ST_POPW_EM: begin
            if (slot_free) begin
               emit    = 1'b1;
               e_dest  = who_ff;
               e_left  = ram_rdata[63:32];
               e_right = ram_rdata[31:0];
               e_last  = 1'b1;
               busy_in[who_idx] = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_DONE_CK: begin
            idx_in   = '0;
            state_in = (all_idle && cnt_ff == '0) ? ST_QUIT : ST_IDLE;
         end
         ST_QUIT: begin
            if (slot_free) begin
               emit   = 1'b1;
               e_kind = KIND_QUIT;
               e_dest = idx_ff + WID_W'(1);
               idx_in = idx_ff + WID_W'(1);
               if (idx_ff + WID_W'(1) == n_ff) begin
                  state_in = ST_TOTAL;
               end
            end
         end
         ST_TOTAL: begin
            if (slot_free) begin
               emit     = 1'b1;
               e_kind   = KIND_TOTAL;
               e_total  = total_ff;
               e_last   = 1'b1;
               run_in   = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // result register: load on emit, drop valid once the transfer completes
   always_comb begin
      ov_in   = ov_ff && !rsp_ch.ready;
      kind_in = kind_ff;
      dest_in = dest_ff;
      tl_in   = tl_ff;
      tr_in   = tr_ff;
      ta_in   = ta_ff;
      ovf_in  = ovf_ff;
      last_in = last_ff;
      if (emit) begin
         ov_in   = 1'b1;
         kind_in = e_kind;
         dest_in = e_dest;
         tl_in   = e_left;
         tr_in   = e_right;
         ta_in   = e_total;
         ovf_in  = drop_ff;
         last_in = e_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wc_ff    <= RST_WORKER_COUNT;
         rlo_ff   <= RST_RANGE_LOW;
         rhi_ff   <= RST_RANGE_HIGH;
         state_ff <= ST_IDLE;
         n_ff     <= WID_W'(1);
         cnt_ff   <= '0;
         busy_ff  <= '0;
         total_ff <= '0;
         run_ff   <= 1'b0;
         drop_ff  <= 1'b0;
         ov_ff    <= 1'b0;
      end else begin
         wc_ff    <= wc_in;
         rlo_ff   <= rlo_in;
         rhi_ff   <= rhi_in;
         state_ff <= state_in;
         n_ff     <= n_in;
         cnt_ff   <= cnt_in;
         busy_ff  <= busy_in;
         total_ff <= total_in;
         run_ff   <= run_in;
         drop_ff  <= drop_in;
         ov_ff    <= ov_in;
      end
      who_ff   <= who_in;
      found_ff <= found_in;
      idx_ff   <= idx_in;
      jcnt_ff  <= jcnt_in;
      p_ff     <= p_in;
      step_ff  <= step_in;
      left_ff  <= left_in;
      mid_ff   <= mid_in;
      right_ff <= right_in;
      kind_ff  <= kind_in;
      dest_ff  <= dest_in;
      tl_ff    <= tl_in;
      tr_ff    <= tr_in;
      ta_ff    <= ta_in;
      ovf_ff   <= ovf_in;
      last_ff  <= last_in;
   end

   assign rsp_ch.valid       = ov_ff;
   assign rsp_ch.kind        = kind_ff;
   assign rsp_ch.dest_worker = dest_ff;
   assign rsp_ch.task_left   = tl_ff;
   assign rsp_ch.task_right  = tr_ff;
   assign rsp_ch.total_area  = ta_ff;
   assign rsp_ch.overflow    = ovf_ff;
   assign rsp_ch.last        = last_ff;

   // stack fill never passes the depth
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(STACK_DEPTH))
      else $error("stack count past depth");

   // the final total always carries last and destination zero
   a_total_last: assert property (@(posedge clock) disable iff (reset)
      ov_ff && kind_ff == KIND_TOTAL |-> last_ff && dest_ff == '0)
      else $error("total without last");

   // an accepted start always hands off to the divider
   a_start_div: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready && req_ch.cmd == CMD_START |=> state_ff == ST_DIV)
      else $error("start did not launch divide");

   // a popped task is only issued with a nonempty stack behind it
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_POPF_RD || state_ff == ST_POPW_RD) |-> cnt_ff != '0)
      else $error("pop from empty stack");

endmodule
